// ----- rtl/core/prb_pkg.sv -----
package prb_pkg;

    localparam int OFF_W  = 32;
    localparam int SIZE_W = 11;
    localparam int TAG_W  = 32;

    // stream packing: offset, size, tag from bit 0 up, zero pad to bytes
    localparam int FIELDS_W = OFF_W + SIZE_W + TAG_W;
    localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
    localparam int PAD_W    = TDATA_W - FIELDS_W;
    localparam int TUSER_W  = 4;

    // buffered packets drained per request at most
    localparam int MAX_DRAIN = 8;
    localparam int DRAIN_W   = $clog2(MAX_DRAIN + 1);

    typedef enum logic [1:0] {
        KIND_DELIVER = 2'd0,
        KIND_ACK     = 2'd1,
        KIND_REJECT  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DELIVER,
        ST_SCAN,
        ST_HIT,
        ST_MISS,
        ST_ACK,
        ST_REJECT
    } t_state;

    typedef enum logic {
        SCAN_DRAIN,
        SCAN_LOOKUP
    } t_scan_mode;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [SIZE_W-1:0] size;
        logic [OFF_W-1:0]  offset;
    } t_entry;

    typedef struct packed {
        t_entry entry;
        logic   fin;
    } t_pkt;

    typedef struct packed {
        t_kind             kind;
        logic [OFF_W-1:0]  offset;
        logic [SIZE_W-1:0] size;
        logic [TAG_W-1:0]  tag;
        logic              fin;
        logic              done;
        logic              last;
    } t_result;

endpackage

// ----- rtl/core/prb_slot_mem.sv -----
module prb_slot_mem #(
    parameter int SLOTS = 8,
    parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [IW-1:0]   i_waddr,
    input  prb_pkg::t_entry i_wdata,
    input  logic [IW-1:0]   i_raddr,
    output prb_pkg::t_entry o_rdata
);

    prb_pkg::t_entry r_mem [SLOTS];
    prb_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/prb_out_reg.sv -----
module prb_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  prb_pkg::t_result i_res,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output prb_pkg::t_result o_res
);

    logic             r_valid;
    prb_pkg::t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    // slot can take a new result when empty or being drained this cycle
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ----- rtl/core/prb_ctrl.sv -----
module prb_ctrl #(
    parameter int SLOTS = 8,
    parameter int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    parameter int OW    = $clog2(SLOTS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  prb_pkg::t_pkt    i_pkt,
    output logic             o_res_load,
    output prb_pkg::t_result o_res,
    input  logic             i_out_free,
    output logic             o_mem_we,
    output logic [IW-1:0]    o_mem_waddr,
    output prb_pkg::t_entry  o_mem_wdata,
    output logic [IW-1:0]    o_mem_raddr,
    input  prb_pkg::t_entry  i_mem_rdata
);

    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    prb_pkg::t_state     r_state, n_state;
    prb_pkg::t_scan_mode r_mode, n_mode;

    logic [prb_pkg::OFF_W-1:0]   r_exp, n_exp;
    logic [prb_pkg::OFF_W-1:0]   r_fin_off, n_fin_off;
    logic                        r_fin_known, n_fin_known;
    logic [SLOTS-1:0]            r_valid, n_valid;
    logic [OW-1:0]               r_occ, n_occ;
    logic                        r_done, n_done;
    logic [prb_pkg::DRAIN_W-1:0] r_cnt, n_cnt;

    // scan pipeline: read issue stage and compare stage
    logic [IW-1:0] r_rd_idx, n_rd_idx;
    logic          r_rd_more, n_rd_more;
    logic          r_cmp_vld, n_cmp_vld;
    logic [IW-1:0] r_cmp_idx, n_cmp_idx;
    logic          r_free_found, n_free_found;
    logic [IW-1:0] r_free_idx, n_free_idx;

    prb_pkg::t_pkt   r_in;
    prb_pkg::t_entry r_hit;
    logic [IW-1:0]   r_hit_idx;

    logic [prb_pkg::OFF_W-1:0] key;
    logic                      cmp_hit;
    logic                      cmp_last;
    logic                      hit_fin;
    logic                      in_fin;

    assign key      = (r_mode == prb_pkg::SCAN_DRAIN) ? r_exp : r_in.entry.offset;
    assign cmp_hit  = r_cmp_vld && r_valid[r_cmp_idx] && (i_mem_rdata.offset == key);
    assign cmp_last = (r_cmp_idx == LAST_IDX);
    assign hit_fin  = r_fin_known && (r_hit.offset == r_fin_off);
    assign in_fin   = r_fin_known && (r_in.entry.offset == r_fin_off);

    assign o_mem_raddr = r_rd_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= prb_pkg::SCAN_DRAIN;
            r_exp        <= '0;
            r_fin_off    <= '0;
            r_fin_known  <= 1'b0;
            r_valid      <= '0;
            r_occ        <= '0;
            r_done       <= 1'b0;
            r_cnt        <= '0;
            r_rd_idx     <= '0;
            r_rd_more    <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_cmp_idx    <= '0;
            r_free_found <= 1'b0;
            r_free_idx   <= '0;
        end else begin
            r_mode       <= n_mode;
            r_exp        <= n_exp;
            r_fin_off    <= n_fin_off;
            r_fin_known  <= n_fin_known;
            r_valid      <= n_valid;
            r_occ        <= n_occ;
            r_done       <= n_done;
            r_cnt        <= n_cnt;
            r_rd_idx     <= n_rd_idx;
            r_rd_more    <= n_rd_more;
            r_cmp_vld    <= n_cmp_vld;
            r_cmp_idx    <= n_cmp_idx;
            r_free_found <= n_free_found;
            r_free_idx   <= n_free_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == prb_pkg::ST_IDLE && i_in_valid) begin
            r_in <= i_pkt;
        end
        if (r_state == prb_pkg::ST_SCAN && cmp_hit) begin
            r_hit     <= i_mem_rdata;
            r_hit_idx <= r_cmp_idx;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_exp        = r_exp;
        n_fin_off    = r_fin_off;
        n_fin_known  = r_fin_known;
        n_valid      = r_valid;
        n_occ        = r_occ;
        n_done       = r_done;
        n_cnt        = r_cnt;
        n_rd_idx     = r_rd_idx;
        n_rd_more    = r_rd_more;
        n_cmp_vld    = 1'b0;
        n_cmp_idx    = r_cmp_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        o_in_ready   = 1'b0;
        o_res_load   = 1'b0;
        o_res        = '0;
        o_mem_we     = 1'b0;
        o_mem_waddr  = r_free_idx;
        o_mem_wdata  = r_in.entry;

        case (r_state)
            prb_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_done = 1'b0;
                    if (i_pkt.fin) begin
                        n_fin_off   = i_pkt.entry.offset;
                        n_fin_known = 1'b1;
                    end
                    if (i_pkt.entry.offset == r_exp) begin
                        n_state = prb_pkg::ST_DELIVER;
                    end else begin
                        n_mode       = prb_pkg::SCAN_LOOKUP;
                        n_rd_idx     = '0;
                        n_rd_more    = 1'b1;
                        n_free_found = 1'b0;
                        n_state      = prb_pkg::ST_SCAN;
                    end
                end
            end

            prb_pkg::ST_DELIVER: begin
                if (i_out_free) begin
                    o_res_load    = 1'b1;
                    o_res.kind    = prb_pkg::KIND_DELIVER;
                    o_res.offset  = r_in.entry.offset;
                    o_res.size    = r_in.entry.size;
                    o_res.tag     = r_in.entry.tag;
                    o_res.fin     = in_fin;
                    o_res.done    = in_fin;
                    n_done        = in_fin;
                    n_exp         = r_exp + prb_pkg::OFF_W'(r_in.entry.size);
                    n_cnt         = '0;
                    n_mode        = prb_pkg::SCAN_DRAIN;
                    n_rd_idx      = '0;
                    n_rd_more     = 1'b1;
                    n_state       = prb_pkg::ST_SCAN;
                end
            end

            prb_pkg::ST_SCAN: begin
                // issue the next read while comparing the previous one
                n_cmp_vld = r_rd_more;
                n_cmp_idx = r_rd_idx;
                n_rd_more = r_rd_more && (r_rd_idx != LAST_IDX);
                n_rd_idx  = (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + IW'(1);
                if (r_cmp_vld && !r_valid[r_cmp_idx] && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_cmp_idx;
                end
                if (cmp_hit) begin
                    n_cmp_vld = 1'b0;
                    n_rd_more = 1'b0;
                    n_state   = (r_mode == prb_pkg::SCAN_DRAIN) ? prb_pkg::ST_HIT
                                                                 : prb_pkg::ST_ACK;
                end else if (r_cmp_vld && cmp_last) begin
                    n_state = (r_mode == prb_pkg::SCAN_DRAIN) ? prb_pkg::ST_ACK
                                                                 : prb_pkg::ST_MISS;
                end
            end

            prb_pkg::ST_HIT: begin
                if (i_out_free) begin
                    o_res_load           = 1'b1;
                    o_res.kind           = prb_pkg::KIND_DELIVER;
                    o_res.offset         = r_hit.offset;
                    o_res.size           = r_hit.size;
                    o_res.tag            = r_hit.tag;
                    o_res.fin            = hit_fin;
                    o_res.done           = r_done || hit_fin;
                    n_done               = r_done || hit_fin;
                    n_exp                = r_exp + prb_pkg::OFF_W'(r_hit.size);
                    n_valid[r_hit_idx]   = 1'b0;
                    n_occ                = r_occ - OW'(1);
                    n_cnt                = r_cnt + prb_pkg::DRAIN_W'(1);
                    if (r_cnt == prb_pkg::DRAIN_W'(prb_pkg::MAX_DRAIN - 1)) begin
                        n_state = prb_pkg::ST_ACK;
                    end else begin
                        n_rd_idx  = '0;
                        n_rd_more = 1'b1;
                        n_state   = prb_pkg::ST_SCAN;
                    end
                end
            end

            prb_pkg::ST_MISS: begin
                if (r_in.entry.offset > r_exp) begin
                    if (r_occ == OW'(SLOTS) || !r_free_found) begin
                        n_state = prb_pkg::ST_REJECT;
                    end else begin
                        o_mem_we            = 1'b1;
                        n_valid[r_free_idx] = 1'b1;
                        n_occ               = r_occ + OW'(1);
                        n_state             = prb_pkg::ST_ACK;
                    end
                end else begin
                    n_state = prb_pkg::ST_ACK;
                end
            end

            prb_pkg::ST_ACK: begin
                if (i_out_free) begin
                    o_res_load   = 1'b1;
                    o_res.kind   = prb_pkg::KIND_ACK;
                    o_res.offset = r_in.entry.offset;
                    o_res.fin    = r_in.fin;
                    o_res.done   = r_done;
                    o_res.last   = 1'b1;
                    n_state      = prb_pkg::ST_IDLE;
                end
            end

            prb_pkg::ST_REJECT: begin
                if (i_out_free) begin
                    o_res_load   = 1'b1;
                    o_res.kind   = prb_pkg::KIND_REJECT;
                    o_res.offset = r_in.entry.offset;
                    o_res.last   = 1'b1;
                    n_state      = prb_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = prb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/packet_reorder_buffer.sv -----
// Receiver reorder buffer for a selective-repeat transfer keyed by byte offset.
// Slave stream: one request per arriving packet (offset, size, tag in tdata;
// tlast = final chunk). Master stream: results (offset, size, tag in tdata;
// tuser = kind, final mark, done; tlast = last result of the request).
// A packet at the expected offset is delivered, then stored packets that
// continue the offset are drained in order (at most eight), then one ack.
// Other packets are looked up and stored in the lowest free slot, acked if
// stale or duplicate, or rejected when all slots are taken.
// One request at a time. Every table search sweeps the slot memory
// through its single read port; each drained packet starts a new sweep.
// Reset clears the expected offset, final mark, slot valid bits and
// occupancy; slot contents are not cleared and no sweep is needed.
// When the receiver stalls, the single output register holds its result and
// the sequencer waits; o_s_tready is high only between requests.
module packet_reorder_buffer #(
    parameter int SLOTS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // [31:0] seq_offset, [42:32] pkt_len, [74:43] payload_tag, zero pad
    input  logic [prb_pkg::TDATA_W-1:0] i_s_tdata,
    input  logic                        i_s_tlast,   // is_final
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // [31:0] out_offset, [42:32] out_size, [74:43] out_tag, zero pad
    output logic [prb_pkg::TDATA_W-1:0] o_m_tdata,
    // [1:0] result_kind, [2] out_final, [3] all_done
    output logic [prb_pkg::TUSER_W-1:0] o_m_tuser,
    output logic                        o_m_tlast    // end_of_run
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int SIZE_LO = prb_pkg::OFF_W;
    localparam int TAG_LO  = prb_pkg::OFF_W + prb_pkg::SIZE_W;

    prb_pkg::t_pkt    pkt;
    prb_pkg::t_result res_in;
    prb_pkg::t_result res_out;
    logic             res_load;
    logic             out_free;

    logic            mem_we;
    logic [IW-1:0]   mem_waddr;
    prb_pkg::t_entry mem_wdata;
    logic [IW-1:0]   mem_raddr;
    prb_pkg::t_entry mem_rdata;

    assign pkt.entry.offset = i_s_tdata[prb_pkg::OFF_W-1:0];
    assign pkt.entry.size   = i_s_tdata[SIZE_LO +: prb_pkg::SIZE_W];
    assign pkt.entry.tag    = i_s_tdata[TAG_LO +: prb_pkg::TAG_W];
    assign pkt.fin          = i_s_tlast;

    prb_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_pkt       (pkt),
        .o_res_load  (res_load),
        .o_res       (res_in),
        .i_out_free  (out_free),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    prb_slot_mem #(
        .SLOTS (SLOTS)
    ) u_slot_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    prb_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_load),
        .i_res   (res_in),
        .o_free  (out_free),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (res_out)
    );

    assign o_m_tdata = {{prb_pkg::PAD_W{1'b0}}, res_out.tag, res_out.size, res_out.offset};
    assign o_m_tuser = {res_out.done, res_out.fin, res_out.kind};
    assign o_m_tlast = res_out.last;

endmodule
